### hw/rtl/median_filter_2d_top_defines.svh
// Assertion macros for the checker file of the 2-D median filter.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef MEDIAN_FILTER_2D_TOP_DEFINES_SVH
`define MEDIAN_FILTER_2D_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MF2D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MF2D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mf2d_pkg.sv
// Package of the 2-D median filter: pixel types, register codes, control structs.
// No dependencies; compiled before the interfaces and all modules.
package mf2d_pkg;

	localparam int PIX_W      = 8;
	localparam int CHAN_N     = 3;
	localparam int POS_W      = 10;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 11;

	// Channel 0 red, 1 green, 2 blue.
	typedef logic [CHAN_N-1:0][PIX_W-1:0] rgb_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RADIUS       = 4'd0,
		CFG_FRAME_WIDTH  = 4'd1,
		CFG_FRAME_HEIGHT = 4'd2,
		CFG_GRAY_MODE    = 4'd3
	} cfg_idx_t;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Controls from the sequencer to the selector.
	typedef struct packed {
		logic clear;
		logic shift;
		logic rotate;
	} sel_ctrl_t;

endpackage

### hw/rtl/mf2d_if.sv
// Channel interfaces of the 2-D median filter: pixel input, result output, config write.
// Depends on mf2d_pkg.
interface mf2d_in_if;
	import mf2d_pkg::*;
	logic             valid;
	logic             ready;
	logic             command;
	logic [PIX_W-1:0] in_red;
	logic [PIX_W-1:0] in_green;
	logic [PIX_W-1:0] in_blue;
	modport source (output valid, command, in_red, in_green, in_blue, input ready);
	modport sink   (input valid, command, in_red, in_green, in_blue, output ready);
endinterface

interface mf2d_out_if;
	import mf2d_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_red;
	logic [PIX_W-1:0] out_green;
	logic [PIX_W-1:0] out_blue;
	logic [POS_W-1:0] pixel_column;
	logic [POS_W-1:0] pixel_row;
	logic             frame_end;
	modport source (output valid, out_red, out_green, out_blue, pixel_column, pixel_row,
		frame_end, input ready);
	modport sink   (input valid, out_red, out_green, out_blue, pixel_column, pixel_row,
		frame_end, output ready);
endinterface

interface mf2d_cfg_if;
	import mf2d_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/median_filter_2d_top.sv
// Top level of the streaming 2-D median filter with edge clamping.
// Depends on mf2d_pkg, the interfaces in mf2d_if and the selector mf2d_select.
//
// Pixels enter in raster order, one per transfer; each output is the per-channel median of
// the (2r+1)x(2r+1) window around it, edges clamped, leaving in raster order as soon as
// its window is complete. A drain transfer (command 1) carries no pixel and only lets a
// pending output leave. A write to a known register restarts the frame and drops pending
// state; the configuration port is ready only while the block is idle, and a pending
// configuration write holds off the pixel input. An item that gives no result only
// passes through the check state. An item that gives a result is followed by n = (2r+1)^2
// window reads, one per cycle from the line memory, after which the
// selector rotates all WIN_MAX = (2*MAX_RADIUS+1)^2 ring slots past its compare row; no
// new item is taken until the result has moved to the output register.
// A finished result waits in the output register while the next transfer is taken. The
// line memory holds (2*MAX_RADIUS+1)*MAX_WIDTH pixels and needs no clearing after reset.
module median_filter_2d_top
	import mf2d_pkg::*;
#(
	parameter int MAX_RADIUS = 3,
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	mf2d_in_if.sink    pixels,
	mf2d_out_if.source results,
	mf2d_cfg_if.sink   cfg
);

	localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
	localparam int WIN_MAX  = SIDE_MAX * SIDE_MAX;
	localparam int CNT_W    = $clog2(WIN_MAX + 1);
	localparam int DEPTH    = SIDE_MAX * MAX_WIDTH;
	localparam int AW       = $clog2(DEPTH);
	localparam int DW       = AW + 1;
	localparam int CW       = $clog2(MAX_WIDTH);
	localparam int HW       = $clog2(MAX_HEIGHT);
	localparam int RW       = $clog2(MAX_RADIUS + 1);
	localparam int IW       = $clog2(SIDE_MAX);
	localparam int CSW      = CW + 2;
	localparam int HSW      = HW + 2;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CHECK  = 5'b00010,
		ST_LOAD   = 5'b00100,
		ST_SELECT = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [1:0]            radius_q;
	logic [CFG_DATA_W-1:0] width_q, height_q;
	logic                  gray_q;

	// Positions, write pointer, next-frame flag, address of the output pixel.
	logic [CW-1:0] icol_q, ocol_q;
	logic [HW-1:0] irow_q, orow_q;
	logic [AW-1:0] wptr_q, aout_q;
	logic          nf_q;

	// Window walk.
	logic [IW-1:0]    ix_q, iy_q;
	logic             issuing_q;
	logic [CNT_W-1:0] load_cnt_q, n_q, half_q;
	logic [CNT_W:0]   sel_cnt_q;
	logic signed [DW-1:0] d_s1;
	logic             v_s1, v_s2;
	rgb_t             rdata_s2;

	// Output register.
	logic             out_valid_q;
	rgb_t             out_pix_q;
	logic [POS_W-1:0] out_col_q, out_row_q;
	logic             out_end_q;

	rgb_t mem [DEPTH];

	logic [RW-1:0] r_eff;
	logic [CW:0]   w_eff;
	logic [HW:0]   h_eff;
	logic [IW-1:0] side;
	logic [CNT_W-1:0] n_c;
	logic in_xfer, cfg_xfer, out_xfer, emit_go;
	logic pending, complete;
	logic [HW:0] need_row;
	logic [CW:0] need_col;
	logic signed [CSW-1:0] tcol, dcol;
	logic signed [HSW-1:0] trow, drow;
	logic signed [DW-1:0]  d_c;
	logic signed [DW:0]    asum;
	logic [AW-1:0]         raddr;
	logic last_issue;
	sel_ctrl_t sel_ctrl;
	rgb_t      med;

	// Out-of-range registers fall back to the nearest legal value.
	always_comb begin
		r_eff = (32'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_q);
		if (width_q == '0) w_eff = (CW + 1)'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = (CW + 1)'(MAX_WIDTH);
		else w_eff = (CW + 1)'(width_q);
		if (height_q == '0) h_eff = (HW + 1)'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = (HW + 1)'(MAX_HEIGHT);
		else h_eff = (HW + 1)'(height_q);
		side = IW'({r_eff, 1'b1});
		n_c  = CNT_W'(side) * CNT_W'(side);
	end

	// Take configuration only when idle; a waiting write holds the pixel input.
	assign pixels.ready = (state_q == ST_IDLE) & ~cfg.valid;
	assign cfg.ready    = (state_q == ST_IDLE);
	assign in_xfer      = pixels.valid & pixels.ready;
	assign cfg_xfer     = cfg.valid & cfg.ready;
	assign out_xfer     = results.valid & results.ready;
	assign emit_go      = (state_q == ST_EMIT) & (~out_valid_q | results.ready);

	// Readiness: an output is pending and the bottom-right pixel of its window has arrived.
	always_comb begin
		if ((HW + 1)'(orow_q) + (HW + 1)'(r_eff) > h_eff - 1'b1) need_row = h_eff - 1'b1;
		else need_row = (HW + 1)'(orow_q) + (HW + 1)'(r_eff);
		if ((CW + 1)'(ocol_q) + (CW + 1)'(r_eff) > w_eff - 1'b1) need_col = w_eff - 1'b1;
		else need_col = (CW + 1)'(ocol_q) + (CW + 1)'(r_eff);
		pending  = nf_q || (irow_q > orow_q) || ((irow_q == orow_q) && (icol_q > ocol_q));
		complete = nf_q || ((HW + 1)'(irow_q) > need_row)
			|| (((HW + 1)'(irow_q) == need_row) && ((CW + 1)'(icol_q) > need_col));
	end

	// Clamped offset of the current window pixel from the output pixel.
	always_comb begin
		tcol = CSW'(ocol_q) + CSW'(ix_q) - CSW'(r_eff);
		trow = HSW'(orow_q) + HSW'(iy_q) - HSW'(r_eff);
		if (tcol < 0) dcol = -CSW'(ocol_q);
		else if (tcol > CSW'(w_eff) - 1) dcol = CSW'(w_eff) - 1 - CSW'(ocol_q);
		else dcol = CSW'(ix_q) - CSW'(r_eff);
		if (trow < 0) drow = -HSW'(orow_q);
		else if (trow > HSW'(h_eff) - 1) drow = HSW'(h_eff) - 1 - HSW'(orow_q);
		else drow = HSW'(iy_q) - HSW'(r_eff);
		d_c = DW'(drow) * DW'(signed'(CSW'(w_eff))) + DW'(dcol);
		last_issue = (ix_q == side - 1'b1) && (iy_q == side - 1'b1);
	end

	// Read address: output pixel address plus offset, wrapped once around the ring.
	always_comb begin
		asum = signed'((DW + 1)'(aout_q)) + (DW + 1)'(d_s1);
		if (asum < 0) asum = asum + (DW + 1)'(DEPTH);
		else if (asum >= (DW + 1)'(DEPTH)) asum = asum - (DW + 1)'(DEPTH);
		raddr = asum[AW-1:0];
	end

	always_comb begin
		sel_ctrl.clear  = (state_q == ST_CHECK);
		sel_ctrl.shift  = (state_q == ST_LOAD) & v_s2;
		sel_ctrl.rotate = (state_q == ST_SELECT) & (sel_cnt_q < (CNT_W + 1)'(WIN_MAX));
	end

	// Line memory: write on pixel transfer, read during the window walk.
	always_ff @(posedge clk) begin
		if (in_xfer && (pixels.command == CMD_PIXEL)) begin
			mem[wptr_q] <= {pixels.in_blue, pixels.in_green, pixels.in_red};
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) rdata_s2 <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		d_s1 <= d_c;
	end

	// Sequencer and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radius_q    <= 2'd1;
			width_q     <= CFG_DATA_W'(640);
			height_q    <= CFG_DATA_W'(480);
			gray_q      <= 1'b0;
			icol_q      <= '0;
			irow_q      <= '0;
			ocol_q      <= '0;
			orow_q      <= '0;
			wptr_q      <= '0;
			aout_q      <= '0;
			nf_q        <= 1'b0;
			ix_q        <= '0;
			iy_q        <= '0;
			issuing_q   <= 1'b0;
			load_cnt_q  <= '0;
			n_q         <= '0;
			half_q      <= '0;
			sel_cnt_q   <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_LOAD) & issuing_q;
			v_s2 <= v_s1;
			if (out_xfer) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (cfg_xfer) begin
						case (cfg.index)
							CFG_RADIUS:       radius_q <= cfg.data[1:0];
							CFG_FRAME_WIDTH:  width_q  <= cfg.data;
							CFG_FRAME_HEIGHT: height_q <= cfg.data;
							CFG_GRAY_MODE:    gray_q   <= cfg.data[0];
							default: ;
						endcase
						// Restart the frame on any known register.
						if (cfg.index == CFG_RADIUS || cfg.index == CFG_FRAME_WIDTH
							|| cfg.index == CFG_FRAME_HEIGHT || cfg.index == CFG_GRAY_MODE) begin
							icol_q <= '0;
							irow_q <= '0;
							ocol_q <= '0;
							orow_q <= '0;
							wptr_q <= '0;
							aout_q <= '0;
							nf_q   <= 1'b0;
						end
					end else if (in_xfer) begin
						if (pixels.command == CMD_PIXEL) begin
							wptr_q <= (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + 1'b1;
							if ((CW + 1)'(icol_q) + 1'b1 >= w_eff) begin
								icol_q <= '0;
								if ((HW + 1)'(irow_q) + 1'b1 >= h_eff) begin
									irow_q <= '0;
									nf_q   <= 1'b1;
								end else begin
									irow_q <= irow_q + 1'b1;
								end
							end else begin
								icol_q <= icol_q + 1'b1;
							end
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (pending && complete) begin
						ix_q       <= '0;
						iy_q       <= '0;
						issuing_q  <= 1'b1;
						load_cnt_q <= '0;
						n_q        <= n_c;
						half_q     <= n_c >> 1;
						state_q    <= ST_LOAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_LOAD: begin
					// Issue one window read a cycle, row by row.
					if (issuing_q) begin
						if (last_issue) begin
							issuing_q <= 1'b0;
						end else if (ix_q == side - 1'b1) begin
							ix_q <= '0;
							iy_q <= iy_q + 1'b1;
						end else begin
							ix_q <= ix_q + 1'b1;
						end
					end
					if (v_s2) load_cnt_q <= load_cnt_q + 1'b1;
					if (load_cnt_q == n_q) begin
						sel_cnt_q <= '0;
						state_q   <= ST_SELECT;
					end
				end
				ST_SELECT: begin
					// The state leaves at a count of WIN_MAX, after the last rotation, so the last compare is ranked.
					sel_cnt_q <= sel_cnt_q + 1'b1;
					if (sel_cnt_q == (CNT_W + 1)'(WIN_MAX)) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						aout_q      <= (32'(aout_q) == DEPTH - 1) ? '0 : aout_q + 1'b1;
						if ((CW + 1)'(ocol_q) + 1'b1 >= w_eff) begin
							ocol_q <= '0;
							if ((HW + 1)'(orow_q) + 1'b1 >= h_eff) begin
								orow_q <= '0;
								nf_q   <= 1'b0;
							end else begin
								orow_q <= orow_q + 1'b1;
							end
						end else begin
							ocol_q <= ocol_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output payload: hold until the next result is loaded.
	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_pix_q[0] <= med[0];
			out_pix_q[1] <= gray_q ? med[0] : med[1];
			out_pix_q[2] <= gray_q ? med[0] : med[2];
			out_col_q    <= POS_W'(ocol_q);
			out_row_q    <= POS_W'(orow_q);
			out_end_q    <= ((CW + 1)'(ocol_q) == w_eff - 1'b1)
				&& ((HW + 1)'(orow_q) == h_eff - 1'b1);
		end
	end

	assign results.valid        = out_valid_q;
	assign results.out_red      = out_pix_q[0];
	assign results.out_green    = out_pix_q[1];
	assign results.out_blue     = out_pix_q[2];
	assign results.pixel_column = out_col_q;
	assign results.pixel_row    = out_row_q;
	assign results.frame_end    = out_end_q;

	mf2d_select #(
		.WIN_MAX (WIN_MAX)
	) u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (sel_ctrl),
		.din    (rdata_s2),
		.half   (half_q),
		.med    (med)
	);

endmodule

### hw/rtl/mf2d_select.sv
// Rank selector: ring of window pixels, rotated past a compare row, median per channel.
// Depends on mf2d_pkg.
module mf2d_select
	import mf2d_pkg::*;
#(
	parameter int WIN_MAX = 49,
	localparam int CNT_W = $clog2(WIN_MAX + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sel_ctrl_t        ctrl,
	input  rgb_t             din,
	input  logic [CNT_W-1:0] half,
	output rgb_t             med
);

	rgb_t               ring_q [WIN_MAX];
	logic [WIN_MAX-1:0] ok_q;
	logic [CHAN_N-1:0][WIN_MAX-1:0] lt_c, eq_c, lt_s1, eq_s1;
	rgb_t               cand_s1;
	logic               cok_s1;
	rgb_t               med_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q   <= '0;
			cok_s1 <= 1'b0;
		end else begin
			cok_s1 <= ctrl.rotate & ok_q[0];
			if (ctrl.clear) begin
				ok_q <= '0;
			end else if (ctrl.shift) begin
				ok_q <= {1'b1, ok_q[WIN_MAX-1:1]};
			end else if (ctrl.rotate) begin
				ok_q <= {ok_q[0], ok_q[WIN_MAX-1:1]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int i = 0; i < WIN_MAX - 1; i++) ring_q[i] <= ring_q[i+1];
			ring_q[WIN_MAX-1] <= din;
		end else if (ctrl.rotate) begin
			for (int i = 0; i < WIN_MAX - 1; i++) ring_q[i] <= ring_q[i+1];
			ring_q[WIN_MAX-1] <= ring_q[0];
		end
	end

	// Compare the candidate at the head against every valid entry.
	always_comb begin
		for (int c = 0; c < CHAN_N; c++) begin
			for (int j = 0; j < WIN_MAX; j++) begin
				lt_c[c][j] = ok_q[j] & (ring_q[j][c] < ring_q[0][c]);
				eq_c[c][j] = ok_q[j] & (ring_q[j][c] == ring_q[0][c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		lt_s1   <= lt_c;
		eq_s1   <= eq_c;
		cand_s1 <= ring_q[0];
	end

	// Keep the candidate whose rank span covers the middle position.
	always_ff @(posedge clk) begin
		logic [CNT_W:0] less, upto;
		for (int c = 0; c < CHAN_N; c++) begin
			less = (CNT_W + 1)'($countones(lt_s1[c]));
			upto = less + (CNT_W + 1)'($countones(eq_s1[c]));
			if (cok_s1 && (less <= {1'b0, half}) && ({1'b0, half} < upto)) begin
				med_q[c] <= cand_s1[c];
			end
		end
	end

	assign med = med_q;

endmodule

### hw/rtl/mf2d_check.sv
// Port-level checker of the 2-D median filter, bound to the top level.
// Depends on median_filter_2d_top_defines.svh.
`include "median_filter_2d_top_defines.svh"

module mf2d_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	// A stalled result stays offered.
	`MF2D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// One item at a time: no transfer in the cycle after a transfer.
	`MF2D_ASSERT_NEXT(a_in_gap, in_valid && in_ready, !in_ready, "input taken on consecutive cycles")

	// A new result appears only after the block was busy, with the input held not ready.
	`MF2D_ASSERT_NOW(a_out_busy, $rose(out_valid), !$past(in_ready), "result raised while idle")

endmodule

bind median_filter_2d_top mf2d_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready)
);

### bench/tb_median_filter_2d_top.sv
`timescale 1ns / 1ps
// Self-checking bench for median_filter_2d_top: raster pixel stream in, filtered pixels out.
// Depends on mf2d_pkg, the mf2d_if interfaces and the RTL of the filter.
module tb_median_filter_2d_top;
	import mf2d_pkg::*;

	localparam int RING_DEPTH = 7 * 1024;
	localparam int WIN_LEN    = 49;
	localparam int STALL_CAP  = 10000;
	localparam int SETTLE     = 200;

	typedef struct {
		logic        cmd;
		logic [23:0] rgb;
	} pixel_item_t;

	typedef struct {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             last;
	} filtered_px_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mf2d_in_if  pix_if ();
	mf2d_out_if res_if ();
	mf2d_cfg_if cfg_if ();

	median_filter_2d_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix_if),
		.results(res_if),
		.cfg(cfg_if)
	);

	always #5 clk = ~clk;

	// Shadow of the filter: registers, positions and the line ring.
	logic [1:0]   sh_radius = 2'd1;
	logic [10:0]  sh_width = 11'd640;
	logic [10:0]  sh_height = 11'd480;
	logic         sh_gray = 1'b0;
	int unsigned  in_col, in_row, out_col, out_row, wr_ptr;
	bit           ahead;
	logic [23:0]  line_ring [RING_DEPTH];

	pixel_item_t  item_backlog [$];
	filtered_px_t median_queue [$];
	pixel_item_t  on_offer;

	int unsigned items_sent = 0;
	int unsigned items_taken = 0;
	int unsigned pixels_out = 0;
	int unsigned errors = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 0;
	int unsigned stall_cycles = 0;

	// No idling on either side for a stretch of the run.
	wire calm = (items_taken >= 500) && (items_taken < 650);

	function automatic int unsigned eff_dim(logic [10:0] v);
		if (v == 0)
			return 1;
		return (v > 1024) ? 1024 : v;
	endfunction

	function automatic int unsigned clamp_at(int p, int unsigned n);
		if (p < 0)
			return 0;
		if (p >= int'(n))
			return n - 1;
		return p;
	endfunction

	function automatic logic [7:0] median_of(logic [7:0] v [WIN_LEN], int n);
		logic [7:0] t;
		int j;
		for (int i = 1; i < n; i++) begin
			t = v[i];
			j = i;
			while (j > 0 && v[j-1] > t) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = t;
		end
		return v[n/2];
	endfunction

	task automatic restart_frame();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		wr_ptr = 0;
		ahead = 0;
	endtask

	// Advance the shadow by one accepted item and queue the pixel it releases, if any.
	task automatic filter_step(pixel_item_t it);
		int unsigned w, h, r, in_lin, out_lin, need_lin, row, col, span, n;
		logic [7:0] vr [WIN_LEN];
		logic [7:0] vg [WIN_LEN];
		logic [7:0] vb [WIN_LEN];
		logic [23:0] px;
		filtered_px_t m;
		w = eff_dim(sh_width);
		h = eff_dim(sh_height);
		r = sh_radius;
		n = 0;
		if (it.cmd == CMD_PIXEL) begin
			line_ring[wr_ptr] = it.rgb;
			wr_ptr = (wr_ptr + 1) % RING_DEPTH;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
				if (in_row >= h) begin
					in_row = 0;
					ahead = 1;
				end
			end
		end
		in_lin = in_row * w + in_col + (ahead ? w * h : 0);
		out_lin = out_row * w + out_col;
		if (out_lin >= in_lin)
			return;
		need_lin = clamp_at(out_row + r, h) * w + clamp_at(out_col + r, w);
		if (need_lin >= in_lin)
			return;
		for (int dy = -int'(r); dy <= int'(r); dy++) begin
			for (int dx = -int'(r); dx <= int'(r); dx++) begin
				row = clamp_at(int'(out_row) + dy, h);
				col = clamp_at(int'(out_col) + dx, w);
				span = (in_lin - (row * w + col)) % RING_DEPTH;
				px = line_ring[(wr_ptr + RING_DEPTH - span) % RING_DEPTH];
				vr[n] = px[7:0];
				vg[n] = px[15:8];
				vb[n] = px[23:16];
				n++;
			end
		end
		m.red = median_of(vr, n);
		m.green = sh_gray ? m.red : median_of(vg, n);
		m.blue = sh_gray ? m.red : median_of(vb, n);
		m.column = out_col[POS_W-1:0];
		m.row = out_row[POS_W-1:0];
		m.last = (out_col == w - 1) && (out_row == h - 1);
		median_queue = {median_queue, m};
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h) begin
				out_row = 0;
				ahead = 0;
			end
		end
	endtask

	// Sender: hold the offered item until its transfer, then offer the next or idle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_if.valid && pix_if.ready) begin
				filter_step(on_offer);
				items_taken++;
			end
			if (!pix_if.valid || pix_if.ready) begin
				if (item_backlog.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
					on_offer = item_backlog.pop_front();
					pix_if.valid <= 1'b1;
					pix_if.command <= on_offer.cmd;
					pix_if.in_red <= on_offer.rgb[7:0];
					pix_if.in_green <= on_offer.rgb[15:8];
					pix_if.in_blue <= on_offer.rgb[23:16];
				end else begin
					pix_if.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each transfer against the oldest expectation; idle at random and
	// once hold off for a long stretch so the filter backs up into its input.
	always @(posedge clk) begin
		filtered_px_t e;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				pixels_out++;
				if (median_queue.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected pixel col %0d row %0d", res_if.pixel_column,
							res_if.pixel_row);
				end else begin
					e = median_queue.pop_front();
					if (res_if.out_red !== e.red || res_if.out_green !== e.green ||
						res_if.out_blue !== e.blue || res_if.pixel_column !== e.column ||
						res_if.pixel_row !== e.row || res_if.frame_end !== e.last) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %h %h %h c%0d r%0d e%0d, got %h %h %h c%0d r%0d e%0d",
								e.red, e.green, e.blue, e.column, e.row, e.last,
								res_if.out_red, res_if.out_green, res_if.out_blue,
								res_if.pixel_column, res_if.pixel_row, res_if.frame_end);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (!hold_done && pixels_out >= 100 && item_backlog.size() > 0) begin
				hold_done = 1;
				hold_left = 2000;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= calm || ($urandom_range(99) >= 33);
			end
		end
	end

	// Watchdog: end the run if nothing moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_CAP) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [10:0] value);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		// Mirror the write; unknown indexes leave everything as it was.
		case (idx)
			CFG_RADIUS:       sh_radius = value[1:0];
			CFG_FRAME_WIDTH:  sh_width = value;
			CFG_FRAME_HEIGHT: sh_height = value;
			CFG_GRAY_MODE:    sh_gray = value[0];
			default:          return;
		endcase
		restart_frame();
	endtask

	task automatic settle();
		while (item_backlog.size() > 0 || pix_if.valid || median_queue.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_mode(logic [1:0] r, logic [10:0] w, logic [10:0] h, logic g);
		settle();
		write_reg(CFG_RADIUS, 11'(r));
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		write_reg(CFG_GRAY_MODE, 11'(g));
	endtask

	function automatic logic [7:0] sample();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic queue_item(logic cmd, logic [23:0] rgb);
		pixel_item_t it;
		it.cmd = cmd;
		it.rgb = rgb;
		item_backlog = {item_backlog, it};
		items_sent++;
	endtask

	task automatic queue_pixel();
		queue_item(CMD_PIXEL, {sample(), sample(), sample()});
	endtask

	task automatic queue_drains(int n);
		repeat (n) queue_item(CMD_DRAIN, {sample(), sample(), sample()});
	endtask

	initial begin
		int unsigned w, h, r, area, nf, cut;
		pix_if.valid = 1'b0;
		pix_if.command = CMD_PIXEL;
		pix_if.in_red = '0;
		pix_if.in_green = '0;
		pix_if.in_blue = '0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_RADIUS;
		cfg_if.data = '0;
		restart_frame();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings, extremes of the samples, a drain that releases nothing.
		queue_item(CMD_PIXEL, 24'h000000);
		queue_item(CMD_PIXEL, 24'hffffff);
		queue_item(CMD_DRAIN, 24'h000000);
		// One-pixel frame without a window: every pixel leaves at once as a frame end.
		set_mode(2'd0, 11'd1, 11'd1, 1'b0);
		queue_item(CMD_PIXEL, 24'h00ff00);
		queue_item(CMD_PIXEL, 24'hff00ff);
		queue_pixel();
		// Largest window over a 3x3 gray frame, then flush and run into the next frame.
		set_mode(2'd3, 11'd3, 11'd3, 1'b1);
		repeat (9) queue_pixel();
		queue_drains(4);
		repeat (2) queue_pixel();
		// Zero width acts as one, oversize height as the maximum.
		set_mode(2'd2, 11'd0, 11'd2047, 1'b0);
		repeat (4) queue_pixel();
		// Oversize width with zero height; a write to an unknown index changes nothing.
		set_mode(2'd1, 11'd2047, 11'd0, 1'b0);
		write_reg(cfg_idx_t'(4'd9), 11'h7ff);
		repeat (5) queue_pixel();
		queue_drains(2);

		// Random: mostly whole frames with random content, some broken frames and noise.
		while (items_sent < 1100) begin
			r = $urandom_range(3);
			if ($urandom_range(11) == 0) begin
				case ($urandom_range(2))
					0: begin w = 1024; h = $urandom_range(1, 2); end
					1: begin w = 1; h = 1024; end
					default: begin w = $urandom_range(1000, 1024); h = 1024; end
				endcase
			end else begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 8);
			end
			set_mode(2'(r), 11'(w), 11'(h), 1'($urandom_range(1)));
			area = w * h;
			if (area > 120) begin
				repeat ($urandom_range(20, 50)) queue_pixel();
				queue_drains(r + 2);
			end else begin
				nf = $urandom_range(1, 3);
				repeat (nf) begin
					cut = ($urandom_range(9) == 0) ? $urandom_range(1, area) : area;
					for (int i = 0; i < cut; i++) begin
						if ($urandom_range(99) < 10)
							queue_drains(1);
						queue_pixel();
					end
					if ($urandom_range(1))
						queue_drains($urandom_range(1, 3));
				end
				queue_drains((r + 1) * w + r + 2);
			end
		end
		settle();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
